@@ rtl/fhdc_pkg.sv @@
`default_nettype none

package fhdc_pkg;

  // Width of the switch delay counter
  localparam int unsigned DelayBits = 8;
  localparam logic [DelayBits-1:0] DelayMax = {DelayBits{1'b1}};
  // Common width for counter against switch_delay compare
  localparam int unsigned CmpW = (DelayBits > 8) ? DelayBits : 8;

  // Battery below this level (tenths of a volt) counts as low
  localparam logic [9:0] BattLow = 10'd100;

  // Config write data covers the widest register
  localparam int unsigned CfgDataW = 14;

  // mode_bits positions
  localparam int unsigned ModeEnable    = 0;
  localparam int unsigned ModeCrankCut  = 1;
  localparam int unsigned ModeAcLink    = 2;
  localparam int unsigned ModeFanIdleup = 3;
  localparam int unsigned ModeAcIdleup  = 4;

  // Register indexes
  typedef enum logic [2:0] {
    RegOnTemp      = 3'd0,
    RegOffTemp     = 3'd1,
    RegThrottleOff = 3'd2,
    RegThrottleHys = 3'd3,
    RegSpeedOff    = 3'd4,
    RegSpeedHys    = 3'd5,
    RegSwitchDelay = 3'd6,
    RegModeBits    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [12:0] on_temp;
    logic signed [12:0] off_temp;
    logic [9:0]         throttle_off_point;
    logic [9:0]         throttle_hysteresis;
    logic [13:0]        speed_off_point;
    logic [13:0]        speed_hysteresis;
    logic [7:0]         switch_delay;
    logic [4:0]         mode_bits;
  } cfg_t;

  typedef struct packed {
    logic signed [12:0] coolant_temp;
    logic [9:0]         throttle;
    logic [13:0]        vehicle_speed;
    logic               speed_used;
    logic [9:0]         battery;
    logic               engine_running;
    logic               cranking;
    logic               ac_request;
    logic               tick;
  } item_t;

  typedef struct packed {
    logic                 fan_enabled;
    logic                 throttle_hyst_active;
    logic                 speed_hyst_active;
    logic                 fan_demand;
    logic [DelayBits-1:0] delay_count;
    logic                 fan_pin;
    logic                 idleup_flag;
  } state_t;

endpackage

`default_nettype wire

@@ rtl/fan_hysteresis_delay_control_top.sv @@
`default_nettype none

// Radiator fan controller with delayed switching and hysteresis cutoffs.
// Input channel (in_valid_i/in_ready_o) carries one sensor sample per
// transfer; output channel (out_valid_o/out_ready_i) returns exactly one
// result per sample: fan_on_o (fan pin level) and idleup_engaged_o.
// Config channel (cfg_valid_i/cfg_ready_o) writes register cfg_index_i
// with cfg_data_i; it is always ready and must only be used while idle.
// Each sample passes the input register, then evaluation into the result
// register and controller state, before its result transfers.
// Throughput: one sample per cycle while the receiver takes results; the
// state loop closes through the evaluation logic into the state register.
// Reset: control state clears, registers load their defaults (fan off,
// controller disabled), both pipeline stages empty.
// Receiver stall: the result register holds; one more sample may be
// taken into the input register, then in_ready_o drops until the result
// transfers.
module fan_hysteresis_delay_control_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // config
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [2:0]                     cfg_index_i,
  input  wire logic [fhdc_pkg::CfgDataW-1:0]  cfg_data_i,
  // input samples
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic signed [12:0]             coolant_temp_i,
  input  wire logic [9:0]                     throttle_i,
  input  wire logic [13:0]                    vehicle_speed_i,
  input  wire logic                           speed_used_i,
  input  wire logic [9:0]                     battery_i,
  input  wire logic                           engine_running_i,
  input  wire logic                           cranking_i,
  input  wire logic                           ac_request_i,
  input  wire logic                           tick_i,
  // results
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                fan_on_o,
  output logic                                idleup_engaged_o
);

  fhdc_pkg::cfg_t   cfg_q;
  fhdc_pkg::item_t  item_q;
  fhdc_pkg::state_t st_q;
  fhdc_pkg::state_t st_d;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             fan_on_q;
  logic             idleup_q;
  logic             advance;

  assign cfg_ready_o = 1'b1;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_temp             <= 13'sd2000;
      cfg_q.off_temp            <= 13'sd1900;
      cfg_q.throttle_off_point  <= 10'd1000;
      cfg_q.throttle_hysteresis <= 10'd50;
      cfg_q.speed_off_point     <= 14'd16383;
      cfg_q.speed_hysteresis    <= 14'd50;
      cfg_q.switch_delay        <= 8'd10;
      cfg_q.mode_bits           <= 5'd0;
    end else if (cfg_valid_i) begin
      case (fhdc_pkg::cfg_idx_e'(cfg_index_i))
        fhdc_pkg::RegOnTemp:      cfg_q.on_temp             <= $signed(cfg_data_i[12:0]);
        fhdc_pkg::RegOffTemp:     cfg_q.off_temp            <= $signed(cfg_data_i[12:0]);
        fhdc_pkg::RegThrottleOff: cfg_q.throttle_off_point  <= cfg_data_i[9:0];
        fhdc_pkg::RegThrottleHys: cfg_q.throttle_hysteresis <= cfg_data_i[9:0];
        fhdc_pkg::RegSpeedOff:    cfg_q.speed_off_point     <= cfg_data_i[13:0];
        fhdc_pkg::RegSpeedHys:    cfg_q.speed_hysteresis    <= cfg_data_i[13:0];
        fhdc_pkg::RegSwitchDelay: cfg_q.switch_delay        <= cfg_data_i[7:0];
        fhdc_pkg::RegModeBits:    cfg_q.mode_bits           <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Evaluate moves the input stage into the result stage
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.coolant_temp   <= coolant_temp_i;
      item_q.throttle       <= throttle_i;
      item_q.vehicle_speed  <= vehicle_speed_i;
      item_q.speed_used     <= speed_used_i;
      item_q.battery        <= battery_i;
      item_q.engine_running <= engine_running_i;
      item_q.cranking       <= cranking_i;
      item_q.ac_request     <= ac_request_i;
      item_q.tick           <= tick_i;
    end
  end

  fhdc_eval u_eval (
    .st_i   (st_q),
    .cfg_i  (cfg_q),
    .item_i (item_q),
    .st_o   (st_d)
  );

  // Controller state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      out_valid_q <= 1'b0;
      fan_on_q    <= 1'b0;
      idleup_q    <= 1'b0;
    end else begin
      if (advance) begin
        st_q        <= st_d;
        out_valid_q <= 1'b1;
        fan_on_q    <= st_d.fan_pin;
        idleup_q    <= st_d.idleup_flag;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign fan_on_o         = fan_on_q;
  assign idleup_engaged_o = idleup_q;

`ifndef SYNTH
  // The pin is only ever driven while the fan is enabled
  a_pin_implies_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.fan_pin |-> st_q.fan_enabled)
    else $error("fan pin set while fan not enabled");

  // A disabled controller never moves the pin
  a_disabled_holds_pin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !cfg_q.mode_bits[fhdc_pkg::ModeEnable]) |=> $stable(st_q.fan_pin))
    else $error("fan pin changed while disabled");

  // Every evaluation produces a result
  a_advance_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("evaluation without result");

  // Backpressure only when both stages are full and the result stalls
  a_ready_low_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a full pipeline");
`endif

endmodule

`default_nettype wire

@@ rtl/fhdc_eval.sv @@
`default_nettype none

// Next-state logic for one item: tick, mode cutoffs, hysteresis cutoffs,
// demand rise, demand fall, in that order.
module fhdc_eval (
  input  wire fhdc_pkg::state_t st_i,
  input  wire fhdc_pkg::cfg_t   cfg_i,
  input  wire fhdc_pkg::item_t  item_i,
  output fhdc_pkg::state_t      st_o
);

  localparam int unsigned CmpW = fhdc_pkg::CmpW;

  fhdc_pkg::state_t   nxt;
  logic               stop;
  logic               cut;
  logic               on_cond;
  logic               off_cond;
  logic               ac_hold;
  logic               cnt_ge;
  logic [fhdc_pkg::DelayBits-1:0] cnt_tick;
  logic signed [11:0] thr_lim;
  logic signed [15:0] spd_lim;
  logic               thr_over;
  logic               thr_band;
  logic               spd_over;
  logic               spd_band;

  // Tick advances the counter, saturating
  assign cnt_tick = (item_i.tick && (st_i.delay_count != fhdc_pkg::DelayMax)) ?
                    st_i.delay_count + 1'b1 : st_i.delay_count;

  assign cnt_ge = CmpW'(cnt_tick) >= CmpW'(cfg_i.switch_delay);

  // Temperature and A/C conditions
  assign ac_hold  = item_i.ac_request && cfg_i.mode_bits[fhdc_pkg::ModeAcLink];
  assign on_cond  = (item_i.coolant_temp >= cfg_i.on_temp) || ac_hold;
  assign off_cond = (item_i.coolant_temp <= cfg_i.off_temp) && !ac_hold;

  // Hysteresis limits are signed differences
  assign thr_lim  = $signed(12'(cfg_i.throttle_off_point) - 12'(cfg_i.throttle_hysteresis));
  assign spd_lim  = $signed(16'(cfg_i.speed_off_point) - 16'(cfg_i.speed_hysteresis));
  assign thr_over = item_i.throttle > cfg_i.throttle_off_point;
  assign thr_band = $signed({2'b00, item_i.throttle}) > thr_lim;
  assign spd_over = item_i.vehicle_speed >= cfg_i.speed_off_point;
  assign spd_band = $signed({2'b00, item_i.vehicle_speed}) >= spd_lim;

  always_comb begin
    nxt = st_i;
    nxt.delay_count = cnt_tick;
    stop = 1'b0;
    cut  = 1'b0;

    // Enable and mode cutoffs
    if (!cfg_i.mode_bits[fhdc_pkg::ModeEnable]) begin
      stop = 1'b1;
    end else if (!cfg_i.mode_bits[fhdc_pkg::ModeCrankCut] ? !item_i.engine_running :
                 (item_i.cranking || (item_i.battery < fhdc_pkg::BattLow))) begin
      nxt.fan_pin = 1'b0;
      stop = 1'b1;
    end

    // Throttle and speed cutoffs while the fan is enabled
    if (!stop && st_i.fan_enabled) begin
      if (thr_over) begin
        nxt.throttle_hyst_active = 1'b1;
        cut = 1'b1;
      end else if (st_i.throttle_hyst_active && thr_band) begin
        cut = 1'b1;
      end else begin
        nxt.throttle_hyst_active = 1'b0;
      end
      if (item_i.speed_used) begin
        if (spd_over) begin
          nxt.speed_hyst_active = 1'b1;
          cut = 1'b1;
        end else if (st_i.speed_hyst_active && spd_band) begin
          cut = 1'b1;
        end else begin
          nxt.speed_hyst_active = 1'b0;
        end
      end
      if (cut) begin
        nxt.fan_pin = 1'b0;
      end
    end

    // Demand rise
    if (!stop && on_cond) begin
      if (!st_i.fan_demand) begin
        nxt.fan_demand  = 1'b1;
        nxt.delay_count = '0;
        if (cfg_i.mode_bits[fhdc_pkg::ModeFanIdleup] ||
            cfg_i.mode_bits[fhdc_pkg::ModeAcIdleup]) begin
          nxt.idleup_flag          = 1'b1;
          nxt.throttle_hyst_active = 1'b0;
          nxt.speed_hyst_active    = 1'b0;
        end
        stop = 1'b1;
      end else if (cnt_ge && !cut) begin
        nxt.fan_pin     = 1'b1;
        nxt.fan_enabled = 1'b1;
      end
    end

    // Demand fall
    if (!stop && off_cond) begin
      if (st_i.fan_demand) begin
        nxt.fan_demand  = 1'b0;
        nxt.delay_count = '0;
        if (cfg_i.mode_bits[fhdc_pkg::ModeFanIdleup]) begin
          nxt.idleup_flag = 1'b0;
        end
      end else if (cnt_ge) begin
        nxt.fan_pin     = 1'b0;
        nxt.fan_enabled = 1'b0;
      end
    end
  end

  assign st_o = nxt;

endmodule

`default_nettype wire

@@ verif/tb_fan_hysteresis_delay_control_top.sv @@
module tb_fan_hysteresis_delay_control_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fhdc_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PhaseCount = 12;
  localparam int PhaseItems = 130;

  typedef logic [CfgDataW-1:0] cfg_word_t;

  typedef struct packed {
    logic fan_on;
    logic idleup_engaged;
  } fan_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  cfg_idx_e    cfg_index_i = RegOnTemp;
  cfg_word_t   cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  item_t       in_item = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        fan_on_o;
  logic        idleup_engaged_o;

  // Predictor copy of the registers and the controller state
  cfg_t        model_cfg;
  state_t      model_st;
  fan_result_t fan_expect_q[$];

  int          err_count = 0;
  int          cycle_count = 0;
  int          tx_idle_pct = 12;
  int          rx_idle_pct = 80;

  fan_hysteresis_delay_control_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .coolant_temp_i   (in_item.coolant_temp),
    .throttle_i       (in_item.throttle),
    .vehicle_speed_i  (in_item.vehicle_speed),
    .speed_used_i     (in_item.speed_used),
    .battery_i        (in_item.battery),
    .engine_running_i (in_item.engine_running),
    .cranking_i       (in_item.cranking),
    .ac_request_i     (in_item.ac_request),
    .tick_i           (in_item.tick),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .fan_on_o         (fan_on_o),
    .idleup_engaged_o (idleup_engaged_o)
  );

  always #5ns clk_i = ~clk_i;

  // Run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic cfg_t mk_cfg(int on_t, int off_t, int toff, int thys, int soff,
                                  int shys, int dly, int mode);
    cfg_t c;
    c.on_temp             = 13'(on_t);
    c.off_temp            = 13'(off_t);
    c.throttle_off_point  = 10'(toff);
    c.throttle_hysteresis = 10'(thys);
    c.speed_off_point     = 14'(soff);
    c.speed_hysteresis    = 14'(shys);
    c.switch_delay        = 8'(dly);
    c.mode_bits           = 5'(mode);
    return c;
  endfunction

  function automatic item_t mk_sample(int clt, int tps, int vss, bit su, int batt,
                                      bit rdy, bit crk, bit ac, bit tk);
    item_t it;
    it.coolant_temp   = 13'(clt);
    it.throttle       = 10'(tps);
    it.vehicle_speed  = 14'(vss);
    it.speed_used     = su;
    it.battery        = 10'(batt);
    it.engine_running = rdy;
    it.cranking       = crk;
    it.ac_request     = ac;
    it.tick           = tk;
    return it;
  endfunction

  // One controller evaluation: tick, mode cutoffs, hysteresis cutoffs,
  // then the demand-on and demand-off parts
  function automatic void advance_fan(input item_t it);
    int   clt, tps, vss, toff, soff, on_t, off_t;
    logic cut, ac_hold;
    clt     = $signed(it.coolant_temp);
    tps     = int'(it.throttle);
    vss     = int'(it.vehicle_speed);
    on_t    = $signed(model_cfg.on_temp);
    off_t   = $signed(model_cfg.off_temp);
    toff    = int'(model_cfg.throttle_off_point);
    soff    = int'(model_cfg.speed_off_point);
    cut     = 1'b0;
    ac_hold = it.ac_request && model_cfg.mode_bits[ModeAcLink];

    // ticks count even while disabled
    if (it.tick && model_st.delay_count != DelayMax) begin
      model_st.delay_count = model_st.delay_count + 1'b1;
    end
    if (!model_cfg.mode_bits[ModeEnable]) return;

    if (!model_cfg.mode_bits[ModeCrankCut]) begin
      if (!it.engine_running) begin
        model_st.fan_pin = 1'b0;
        return;
      end
    end else if (it.cranking || it.battery < BattLow) begin
      model_st.fan_pin = 1'b0;
      return;
    end

    // throttle and speed cutoffs only while the fan is enabled
    if (model_st.fan_enabled) begin
      if (tps > toff) begin
        model_st.throttle_hyst_active = 1'b1;
        cut = 1'b1;
      end else if (model_st.throttle_hyst_active &&
                   tps > toff - int'(model_cfg.throttle_hysteresis)) begin
        cut = 1'b1;
      end else begin
        model_st.throttle_hyst_active = 1'b0;
      end
      if (it.speed_used) begin
        if (vss >= soff) begin
          model_st.speed_hyst_active = 1'b1;
          cut = 1'b1;
        end else if (model_st.speed_hyst_active &&
                     vss >= soff - int'(model_cfg.speed_hysteresis)) begin
          cut = 1'b1;
        end else begin
          model_st.speed_hyst_active = 1'b0;
        end
      end
      if (cut) model_st.fan_pin = 1'b0;
    end

    if (clt >= on_t || ac_hold) begin
      if (!model_st.fan_demand) begin
        model_st.fan_demand  = 1'b1;
        model_st.delay_count = '0;
        if (model_cfg.mode_bits[ModeFanIdleup] || model_cfg.mode_bits[ModeAcIdleup]) begin
          model_st.idleup_flag          = 1'b1;
          model_st.throttle_hyst_active = 1'b0;
          model_st.speed_hyst_active    = 1'b0;
        end
        return;
      end
      if (model_st.delay_count >= model_cfg.switch_delay && !cut) begin
        model_st.fan_pin     = 1'b1;
        model_st.fan_enabled = 1'b1;
      end
    end

    if (clt <= off_t && !ac_hold) begin
      if (model_st.fan_demand) begin
        model_st.fan_demand  = 1'b0;
        model_st.delay_count = '0;
        if (model_cfg.mode_bits[ModeFanIdleup]) model_st.idleup_flag = 1'b0;
        return;
      end
      if (model_st.delay_count >= model_cfg.switch_delay) begin
        model_st.fan_pin     = 1'b0;
        model_st.fan_enabled = 1'b0;
      end
    end
  endfunction

  // Track register writes and samples, compare every result transfer
  always @(posedge clk_i) begin : scoreboard
    fan_result_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegOnTemp:      model_cfg.on_temp             = cfg_data_i[12:0];
          RegOffTemp:     model_cfg.off_temp            = cfg_data_i[12:0];
          RegThrottleOff: model_cfg.throttle_off_point  = cfg_data_i[9:0];
          RegThrottleHys: model_cfg.throttle_hysteresis = cfg_data_i[9:0];
          RegSpeedOff:    model_cfg.speed_off_point     = cfg_data_i[13:0];
          RegSpeedHys:    model_cfg.speed_hysteresis    = cfg_data_i[13:0];
          RegSwitchDelay: model_cfg.switch_delay        = cfg_data_i[7:0];
          RegModeBits:    model_cfg.mode_bits           = cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        advance_fan(in_item);
        fan_expect_q.push_back(fan_result_t'{model_st.fan_pin, model_st.idleup_flag});
      end
      if (out_valid_o && out_ready_i) begin
        if (fan_expect_q.size() == 0) begin
          $error("result transfer with no sample outstanding");
          err_count++;
        end else begin
          want = fan_expect_q.pop_front();
          if (fan_on_o !== want.fan_on) begin
            $error("fan_on: expected %0b, got %0b", want.fan_on, fan_on_o);
            err_count++;
          end
          if (idleup_engaged_o !== want.idleup_engaged) begin
            $error("idleup_engaged: expected %0b, got %0b",
                   want.idleup_engaged, idleup_engaged_o);
            err_count++;
          end
        end
      end
    end
  end

  // Drop valid, wait for every outstanding result, then let the pipe settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    // the last sample is queued by the scoreboard at its own transfer edge
    @(posedge clk_i);
    while (fan_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all eight registers back to back while the block is idle
  task automatic load_config(input cfg_t c);
    cfg_idx_e idx;
    wait_idle();
    for (int i = 0; i < 8; i++) begin
      idx = cfg_idx_e'(i);
      cfg_index_i <= idx;
      case (idx)
        RegOnTemp:      cfg_data_i <= cfg_word_t'(c.on_temp);
        RegOffTemp:     cfg_data_i <= cfg_word_t'(c.off_temp);
        RegThrottleOff: cfg_data_i <= cfg_word_t'(c.throttle_off_point);
        RegThrottleHys: cfg_data_i <= cfg_word_t'(c.throttle_hysteresis);
        RegSpeedOff:    cfg_data_i <= cfg_word_t'(c.speed_off_point);
        RegSpeedHys:    cfg_data_i <= cfg_word_t'(c.speed_hysteresis);
        RegSwitchDelay: cfg_data_i <= cfg_word_t'(c.switch_delay);
        default:        cfg_data_i <= cfg_word_t'(c.mode_bits);
      endcase
      cfg_valid_i <= 1'b1;
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // One sample transfer, with optional sender idle cycles ahead of it
  task automatic send_sample(input item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_item    <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic test_directed();
    // reset registers: controller disabled, ticks still count
    send_sample(mk_sample(3000, 0, 0, 0, 130, 1, 0, 0, 1));
    send_sample(mk_sample(-400, 0, 0, 0, 130, 1, 0, 0, 1));

    load_config(mk_cfg(2000, 1900, 500, 100, 8000, 1000, 2,
                       (1 << ModeEnable) | (1 << ModeFanIdleup)));
    send_sample(mk_sample(1000, 0, 0, 0, 130, 1, 0, 0, 1));
    // demand rises exactly at the on threshold, then the delay runs out
    send_sample(mk_sample(2000, 0, 0, 0, 130, 1, 0, 0, 0));
    send_sample(mk_sample(2100, 0, 0, 0, 130, 1, 0, 0, 1));
    send_sample(mk_sample(2100, 0, 0, 0, 130, 1, 0, 0, 1));
    // throttle cutoff, held by hysteresis, then released
    send_sample(mk_sample(2100, 1000, 0, 0, 130, 1, 0, 0, 0));
    send_sample(mk_sample(2100, 450, 0, 0, 130, 1, 0, 0, 0));
    send_sample(mk_sample(2100, 400, 0, 0, 130, 1, 0, 0, 0));
    // speed cutoff, hold at the band edge, release; ignored without sensor
    send_sample(mk_sample(2100, 0, 16383, 1, 130, 1, 0, 0, 0));
    send_sample(mk_sample(2100, 0, 7000, 1, 130, 1, 0, 0, 0));
    send_sample(mk_sample(2100, 0, 6999, 1, 130, 1, 0, 0, 0));
    send_sample(mk_sample(2100, 0, 16383, 0, 130, 1, 0, 0, 0));
    // engine not ready drops the pin
    send_sample(mk_sample(2100, 0, 0, 0, 130, 0, 0, 0, 0));
    send_sample(mk_sample(2100, 0, 0, 0, 130, 1, 0, 0, 0));
    // demand falls exactly at the off threshold
    send_sample(mk_sample(1900, 0, 0, 0, 130, 1, 0, 0, 0));
    send_sample(mk_sample(-400, 0, 0, 0, 130, 1, 0, 0, 1));
    send_sample(mk_sample(-400, 0, 0, 0, 130, 1, 0, 0, 1));
    // battery and cranking do not matter in engine-ready mode
    send_sample(mk_sample(3000, 0, 0, 0, 0, 1, 1, 1, 1));

    // crank/battery mode with A/C link and A/C idle-up
    load_config(mk_cfg(2000, 1900, 1000, 0, 16383, 0, 0,
                       (1 << ModeEnable) | (1 << ModeCrankCut) |
                       (1 << ModeAcLink) | (1 << ModeAcIdleup)));
    send_sample(mk_sample(1000, 0, 0, 0, 100, 1, 0, 1, 0));
    send_sample(mk_sample(1000, 0, 0, 0, 100, 1, 1, 1, 0));
    send_sample(mk_sample(1000, 0, 0, 0, 99, 1, 0, 1, 0));
    send_sample(mk_sample(1000, 1000, 0, 0, 1023, 1, 0, 0, 0));
    send_sample(mk_sample(1000, 0, 16383, 1, 1023, 1, 0, 0, 0));

    // overlapping thresholds, hysteresis wider than the off points
    load_config(mk_cfg(1000, 1500, 10, 1000, 0, 16383, 0,
                       (1 << ModeEnable) | (1 << ModeFanIdleup)));
    send_sample(mk_sample(1200, 5, 0, 0, 500, 1, 0, 0, 0));
    send_sample(mk_sample(1200, 5, 0, 0, 500, 1, 0, 0, 0));
    send_sample(mk_sample(1200, 5, 0, 0, 500, 1, 0, 0, 0));
    send_sample(mk_sample(1200, 11, 0, 1, 500, 1, 0, 0, 0));
    send_sample(mk_sample(1200, 0, 0, 1, 500, 1, 0, 0, 0));
  endtask

  // Counter must saturate: a pin cut after 260 ticks comes back at once
  task automatic test_delay_saturation();
    int tps;
    load_config(mk_cfg(2000, 1900, 900, 0, 16383, 0, 255, 1 << ModeEnable));
    send_sample(mk_sample(1000, 0, 0, 0, 130, 1, 0, 0, 0));
    send_sample(mk_sample(2100, 0, 0, 0, 130, 1, 0, 0, 0));
    for (int i = 0; i < 300; i++) begin
      tps = (i >= 260 && i % 3 == 0) ? 1000 : 0;
      send_sample(mk_sample(2100, tps, 0, 0, 130, 1, 0, 0, 1));
    end
  endtask

  task automatic test_random();
    cfg_t c;
    int   on_t, off_t, lo, hi, clt, dir, tick_pct, mode;
    int   toff, thys, soff, shys, tps, vss, batt;
    bit   ac;
    clt = 1900;
    dir = 1;
    ac  = 1'b0;
    for (int p = 0; p < PhaseCount; p++) begin
      if (p == PhaseCount / 3) begin
        tx_idle_pct = 80;
        rx_idle_pct = 12;
      end
      if (p == 2 * PhaseCount / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      // register settings: two extreme corners, then random
      if (p == 0) begin
        c = mk_cfg(3000, -400, 0, 1000, 0, 16383, 255, 31);
      end else if (p == 1) begin
        c = mk_cfg(-400, 3000, 1000, 0, 16383, 0, 0, 29);
      end else begin
        on_t = int'($urandom_range(3400)) - 400;
        if ($urandom_range(4) != 0) begin
          off_t = on_t - int'($urandom_range(300));
          if (off_t < -400) off_t = -400;
        end else begin
          off_t = int'($urandom_range(3400)) - 400;
        end
        mode = int'($urandom_range(31));
        if ($urandom_range(9) != 0) mode = mode | (1 << ModeEnable);
        c = mk_cfg(on_t, off_t, int'($urandom_range(1000)),
                   int'($urandom_range($urandom_range(3) == 0 ? 1000 : 300)),
                   int'($urandom_range(16383)), int'($urandom_range(4000)),
                   int'($urandom_range($urandom_range(6) == 0 ? 255 : 15)), mode);
      end
      load_config(c);

      on_t  = $signed(c.on_temp);
      off_t = $signed(c.off_temp);
      lo    = ((on_t < off_t) ? on_t : off_t) - 150;
      hi    = ((on_t > off_t) ? on_t : off_t) + 150;
      if (lo < -400) lo = -400;
      if (hi > 3000) hi = 3000;
      toff     = int'(c.throttle_off_point);
      thys     = int'(c.throttle_hysteresis);
      soff     = int'(c.speed_off_point);
      shys     = int'(c.speed_hysteresis);
      tick_pct = int'($urandom_range(30, 100));

      for (int n = 0; n < PhaseItems; n++) begin
        // coolant sweeps back and forth across both thresholds
        if ($urandom_range(99) < 8) begin
          clt = int'($urandom_range(3400)) - 400;
        end else begin
          clt = clt + dir * int'($urandom_range(40));
          if (clt >= hi) begin
            clt = hi;
            dir = -1;
          end else if (clt <= lo) begin
            clt = lo;
            dir = 1;
          end
        end

        case ($urandom_range(9))
          0:       tps = toff + int'($urandom_range(4)) - 2;
          1:       tps = toff - thys + int'($urandom_range(4)) - 2;
          2:       tps = ($urandom_range(1) != 0) ? 1000 : 0;
          default: tps = int'($urandom_range(1000));
        endcase
        if (tps < 0) tps = 0;
        if (tps > 1000) tps = 1000;

        case ($urandom_range(9))
          0:       vss = soff + int'($urandom_range(4)) - 2;
          1:       vss = soff - shys + int'($urandom_range(4)) - 2;
          2:       vss = ($urandom_range(1) != 0) ? 16383 : 0;
          default: vss = int'($urandom_range(16383));
        endcase
        if (vss < 0) vss = 0;
        if (vss > 16383) vss = 16383;

        batt = ($urandom_range(9) != 0) ? int'($urandom_range(100, 1023))
                                        : int'($urandom_range(99));
        if ($urandom_range(9) == 0) ac = ~ac;

        send_sample(mk_sample(clt, tps, vss, $urandom_range(1) != 0, batt,
                              $urandom_range(19) != 0, $urandom_range(15) == 0, ac,
                              $urandom_range(99) < tick_pct));
      end
    end
  endtask

  initial begin
    model_cfg = mk_cfg(2000, 1900, 1000, 50, 16383, 50, 10, 0);
    model_st  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_delay_saturation();
    test_random();
    wait_idle();

    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
